/* design/hte_pkg.sv */
package hte_pkg;

   // fixed field widths of the request and response beats
   localparam int SYM_W      = 8;
   localparam int CODE_W     = 32;
   localparam int LEN_W      = 6;
   localparam int BYTE_W     = 8;
   localparam int PEND_W     = 7;
   localparam int REQ_DATA_W = 48;
   localparam int OP_W       = 2;

   // request kinds carried on req_tuser
   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   // table write port
   typedef struct packed {
      logic              en;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } tbl_wr_type;

   // table read result, registered
   typedef struct packed {
      logic              hit;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } tbl_rd_type;

endpackage

/* design/hte_table.sv */
module hte_table
   import hte_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  tbl_wr_type wr,
   input  logic       rd_en,
   input  logic [SYM_W-1:0] rd_symbol,
   output tbl_rd_type rd
);

   localparam int IDX_W = $clog2(SYMBOL_COUNT);

   logic [CODE_W+LEN_W-1:0] mem_ff [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] vld_ff;
   logic [SYMBOL_COUNT-1:0] vld_in;
   logic                    wr_range;
   logic                    rd_range;
   logic [IDX_W-1:0]        wr_idx;
   logic [IDX_W-1:0]        rd_idx;
   logic                    rd_hit_ff;
   logic                    rd_hit_in;
   logic [CODE_W+LEN_W-1:0] rd_entry_ff;

   // symbols at or above the table depth are ignored
   assign wr_range = {1'b0, wr.symbol} < (SYM_W+1)'(SYMBOL_COUNT);
   assign rd_range = {1'b0, rd_symbol} < (SYM_W+1)'(SYMBOL_COUNT);
   assign wr_idx   = wr.symbol[IDX_W-1:0];
   assign rd_idx   = rd_symbol[IDX_W-1:0];

   // per-entry valid bits stand in for the cleared length store
   always_comb begin
      vld_in = vld_ff;
      if (wr.en && wr_range) begin
         vld_in[wr_idx] = 1'b1;
      end
   end

   always_comb begin
      rd_hit_in = rd_hit_ff;
      if (rd_en) begin
         rd_hit_in = rd_range && vld_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   // code and length memory, registered read
   always_ff @(posedge clock) begin
      if (wr.en && wr_range) begin
         mem_ff[wr_idx] <= {wr.code, wr.len};
      end
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_idx];
      end
   end

   assign rd.hit  = rd_hit_ff;
   assign rd.code = rd_entry_ff[CODE_W+LEN_W-1:LEN_W];
   assign rd.len  = rd_entry_ff[LEN_W-1:0];

endmodule

/* design/huffman_table_encoder_core.sv */
// Huffman table encoder core.
// The req channel carries one beat per command: load a table entry, encode a
// symbol, or flush. The command kind is on req_tuser; symbol, code bits and
// code length are packed on req_tdata. Encoded bytes leave on the rsp channel,
// earliest code bit in bit 7, with rsp_tlast high on the last byte that one
// request produced. Loads, symbols without a code and empty flushes give no
// byte.
// The table read happens at the capture of a beat into the input stage; the
// packing then fills the output register once it is free, and the first byte
// of the request is valid from there. Throughput: one request per cycle
// while each request yields at most one byte and the receiver takes each
// byte; a request yielding more than one byte holds the output register until
// the single byte-wide rsp port has sent them all. Codes up to MAX_CODE_LEN
// bits give at most (MAX_CODE_LEN + 7) / 8 bytes per request.
// Reset clears all table valid bits (no code for any symbol), the pending bits
// and the pipeline. When the receiver stalls, the output register holds its
// byte, one request waits behind it, and req_tready falls.
module huffman_table_encoder_core
   import hte_pkg::*;
#(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] symbol, [39:8] code_value, [45:40] code_length, [47:46] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] out_byte
   output logic [BYTE_W-1:0]     rsp_tdata,
   // last_of_run
   output logic                  rsp_tlast
);

   localparam int ACC_W   = MAX_CODE_LEN + PEND_W;
   localparam int MAX_RSP = ACC_W / BYTE_W;
   localparam int CNT_W   = $clog2(MAX_RSP + 1);
   localparam int TOT_W   = LEN_W + 1;

   logic                    req_fire;
   logic                    rsp_fire;
   logic [OP_W-1:0]         req_op;
   logic [LEN_W-1:0]        req_len;
   logic [LEN_W-1:0]        req_len_sat;
   tbl_wr_type              tbl_wr;
   tbl_rd_type              tbl_rd;

   logic                    s1_vld_ff;
   logic                    s1_vld_in;
   logic [OP_W-1:0]         s1_op_ff;
   logic [OP_W-1:0]         s1_op_in;
   logic [PEND_W-1:0]       pend_ff;
   logic [PEND_W-1:0]       pend_in;
   logic [2:0]              pcnt_ff;
   logic [2:0]              pcnt_in;
   logic [ACC_W-1:0]        emit_w_ff;
   logic [ACC_W-1:0]        emit_w_in;
   logic [CNT_W-1:0]        emit_cnt_ff;
   logic [CNT_W-1:0]        emit_cnt_in;

   logic                    out_free;
   logic                    s1_go;
   logic [LEN_W-1:0]        eff_len;
   logic [MAX_CODE_LEN-1:0] code_ext;
   logic [MAX_CODE_LEN-1:0] code_left;
   logic [TOT_W-1:0]        left_sh;
   logic [ACC_W-1:0]        enc_w;
   logic [TOT_W-1:0]        total;
   logic [ACC_W-1:0]        word;
   logic [CNT_W-1:0]        nbytes;
   logic [CNT_W+2:0]        byte_sh;
   logic [ACC_W-1:0]        rest_w;
   logic [2:0]              new_pcnt;
   logic [PEND_W-1:0]       new_pend;

   // request fields and handshakes
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_op   = req_tuser;
   assign req_len  = req_tdata[45:40];

   // loaded lengths saturate at the longest supported code
   assign req_len_sat = (req_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : req_len;

   assign tbl_wr.en     = req_fire && (req_op == OP_LOAD);
   assign tbl_wr.symbol = req_tdata[7:0];
   assign tbl_wr.code   = req_tdata[39:8];
   assign tbl_wr.len    = req_len_sat;

   hte_table #(
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .rd_en     (req_fire && (req_op == OP_ENCODE)),
      .rd_symbol (req_tdata[7:0]),
      .rd        (tbl_rd)
   );

   // the staged request moves on once the output register is free
   assign out_free   = (emit_cnt_ff == '0) || ((emit_cnt_ff == CNT_W'(1)) && rsp_tready);
   assign s1_go      = s1_vld_ff && out_free;
   assign req_tready = !s1_vld_ff || out_free;

   // code left-aligned behind the pending bits, msb first
   assign eff_len   = tbl_rd.hit ? tbl_rd.len : '0;
   assign code_ext  = MAX_CODE_LEN'(tbl_rd.code);
   assign left_sh   = TOT_W'(MAX_CODE_LEN) - {1'b0, eff_len};
   assign code_left = code_ext << left_sh;
   assign enc_w     = {pend_ff, {MAX_CODE_LEN{1'b0}}} | ({code_left, {PEND_W{1'b0}}} >> pcnt_ff);
   assign total     = TOT_W'(pcnt_ff) + {1'b0, eff_len};

   // word to emit, byte count and leftover bits per command
   always_comb begin
      word     = '0;
      nbytes   = '0;
      new_pcnt = pcnt_ff;
      case (s1_op_ff)
         OP_ENCODE: begin
            word     = enc_w;
            nbytes   = CNT_W'(total >> 3);
            new_pcnt = total[2:0];
         end
         OP_FLUSH: begin
            word     = {pend_ff, {MAX_CODE_LEN{1'b0}}};
            nbytes   = (pcnt_ff != 3'd0) ? CNT_W'(1) : '0;
            new_pcnt = 3'd0;
         end
         default: begin
            word     = {pend_ff, {MAX_CODE_LEN{1'b0}}};
            nbytes   = '0;
            new_pcnt = pcnt_ff;
         end
      endcase
   end

   assign byte_sh  = {nbytes, 3'b000};
   assign rest_w   = word << byte_sh;
   assign new_pend = (s1_op_ff == OP_FLUSH) ? '0 : rest_w[ACC_W-1 -: PEND_W];

   // stage and accumulator next state
   always_comb begin
      s1_vld_in = s1_vld_ff;
      s1_op_in  = s1_op_ff;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      if (s1_go) begin
         s1_vld_in = 1'b0;
         pend_in   = new_pend;
         pcnt_in   = new_pcnt;
      end
      if (req_fire) begin
         s1_vld_in = 1'b1;
         s1_op_in  = req_op;
      end
   end

   // output register: one byte per beat from the top of the word
   always_comb begin
      emit_w_in   = emit_w_ff;
      emit_cnt_in = emit_cnt_ff;
      if (s1_go && (nbytes != '0)) begin
         emit_w_in   = word;
         emit_cnt_in = nbytes;
      end else if (rsp_fire) begin
         emit_w_in   = emit_w_ff << BYTE_W;
         emit_cnt_in = emit_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         pend_ff     <= '0;
         pcnt_ff     <= '0;
         emit_cnt_ff <= '0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         pend_ff     <= pend_in;
         pcnt_ff     <= pcnt_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= s1_op_in;
      emit_w_ff <= emit_w_in;
   end

   assign rsp_tvalid = emit_cnt_ff != '0;
   assign rsp_tdata  = emit_w_ff[ACC_W-1 -: BYTE_W];
   assign rsp_tlast  = emit_cnt_ff == CNT_W'(1);

endmodule
